>>> design/tcw_pkg.sv
// shared types and constants for the text terminal cell writer
// no dependencies; imported by the sweep engine and the top level
`default_nettype none

package tcw_pkg;

  // control characters
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // request from the sequencer to the sweep engine
  typedef struct packed {
    logic go_clear;
    logic go_scroll;
  } sweep_cmd_t;

  // sweep engine status
  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

endpackage

`default_nettype wire

>>> design/tcw_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/tcw_addr_unit.sv
// shared cell address unit: row * COLS + col
// no dependencies; one instance serves cursor writes and cell reads
`default_nettype none

module tcw_addr_unit #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire [$clog2(ROWS)-1:0]        row,
  input  wire [$clog2(COLS)-1:0]        col,
  output logic [$clog2(ROWS*COLS)-1:0]  addr
);

  localparam int AW = $clog2(ROWS * COLS);

  // constant multiply and add
  assign addr = AW'(AW'(row) * AW'(COLS) + AW'(col));

endmodule

`default_nettype wire

>>> design/tcw_sweep.sv
// sweep engine: walks the cell store to clear it or scroll it up one row
// depends on tcw_pkg for the command and status structs and the space code
`default_nettype none

module tcw_sweep
  import tcw_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire                            clk,
  input  wire                            rst,
  input  sweep_cmd_t                     cmd,
  output sweep_stat_t                    stat,
  input  wire [7:0]                      rdata,
  output logic [$clog2(ROWS*COLS)-1:0]   raddr,
  output logic                           we,
  output logic [$clog2(ROWS*COLS)-1:0]   waddr,
  output logic [7:0]                     wdata
);

  localparam int AW    = $clog2(ROWS * COLS);
  localparam int CELLS = ROWS * COLS;
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);

  localparam logic [1:0] SW_IDLE = 2'd0;
  localparam logic [1:0] SW_COPY = 2'd1;
  localparam logic [1:0] SW_FILL = 2'd2;

  logic [1:0]    phase;
  logic [AW-1:0] cnt;
  logic          done;

  // phase and walk counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= SW_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        SW_IDLE: begin
          if (cmd.go_clear) begin
            phase <= SW_FILL;
            cnt   <= '0;
          end else if (cmd.go_scroll) begin
            phase <= SW_COPY;
            cnt   <= '0;
          end
        end
        SW_COPY: begin
          if (cnt == LAST_ROW_BASE) begin
            phase <= SW_FILL;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        SW_FILL: begin
          if (cnt == LAST_CELL) begin
            phase <= SW_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        default: begin
          phase <= SW_IDLE;
        end
      endcase
    end
  end

  // copy reads one row ahead; the registered read data is written in the next cycle, one cell behind
  always_comb begin
    raddr = (cnt == LAST_ROW_BASE) ? '0 : AW'(cnt + AW'(COLS));
    we    = 1'b0;
    waddr = cnt;
    wdata = CH_SPACE;
    if (phase == SW_COPY) begin
      we    = (cnt != '0);
      waddr = cnt - AW'(1);
      wdata = rdata;
    end else if (phase == SW_FILL) begin
      we = 1'b1;
    end
  end

  assign stat.busy = (phase != SW_IDLE);
  assign stat.done = done;

endmodule

`default_nettype wire

>>> design/text_terminal_cell_writer.sv
// text terminal cell writer: put and read sequencer over one cell ram
// a put steps through decode and done, an in-range read adds a ram wait state, and a scroll
// or a form feed adds a sweep state, spent in the cell-by-cell sweep of the store
// one item at a time: tready is low until the result is registered
// reset (rst, synchronous) homes the cursor and runs a clearing pass; tready rises when
// that pass is done; depends on tcw_pkg, tcw_ram, tcw_addr_unit and tcw_sweep
`default_nettype none

module text_terminal_cell_writer
  import tcw_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
  input  wire  [0:0]  s_tuser,   // action[0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // cell_char[7:0], cursor_row[12:8], cursor_col[19:13], zero pad
  output logic [0:0]  m_tuser    // bell[0]
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]       state;
  logic             init_pass;
  logic             act_q;
  logic [7:0]       code_q;
  logic [4:0]       rrow_q;
  logic [6:0]       rcol_q;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [7:0]       res_cell;
  logic             res_bell;

  logic [ROW_W-1:0] row_sel;
  logic [COL_W-1:0] col_sel;
  logic [AW-1:0]    cell_addr;
  logic             rd_in_range;
  logic             col_last;
  logic             row_last;
  logic             is_ctrl;

  sweep_cmd_t       sw_cmd;
  sweep_stat_t      sw_stat;
  logic [AW-1:0]    sw_raddr;
  logic             sw_we;
  logic [AW-1:0]    sw_waddr;
  logic [7:0]       sw_wdata;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  assign s_tready = (state == ST_IDLE);

  // address operands: the read cell for reads, the cursor for puts
  assign row_sel = act_q ? ROW_W'(rrow_q) : cur_row;
  assign col_sel = act_q ? COL_W'(rcol_q) : cur_col;

  tcw_addr_unit #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_addr (
    .row  (row_sel),
    .col  (col_sel),
    .addr (cell_addr)
  );

  assign rd_in_range = ({2'b00, rrow_q} < 7'(ROWS)) && ({1'b0, rcol_q} < 8'(COLS));
  assign col_last    = (cur_col == COL_W'(COLS - 1));
  assign row_last    = (cur_row == ROW_W'(ROWS - 1));
  assign is_ctrl     = (code_q == CH_FF) || (code_q == CH_CR) ||
                       (code_q == CH_LF) || (code_q == CH_BEL);

  // sweep requests from the sequencer
  always_comb begin
    sw_cmd.go_clear  = 1'b0;
    sw_cmd.go_scroll = 1'b0;
    if (state == ST_INIT) begin
      sw_cmd.go_clear = 1'b1;
    end else if (state == ST_DECODE && !act_q) begin
      if (code_q == CH_FF) begin
        sw_cmd.go_clear = 1'b1;
      end else if (code_q == CH_LF) begin
        sw_cmd.go_scroll = row_last;
      end else if (!is_ctrl) begin
        sw_cmd.go_scroll = col_last && row_last;
      end
    end
  end

  tcw_sweep #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_sweep (
    .clk   (clk),
    .rst   (rst),
    .cmd   (sw_cmd),
    .stat  (sw_stat),
    .rdata (ram_rdata),
    .raddr (sw_raddr),
    .we    (sw_we),
    .waddr (sw_waddr),
    .wdata (sw_wdata)
  );

  // ram ports: the sweep owns the store while it runs
  always_comb begin
    if (sw_stat.busy) begin
      ram_we    = sw_we;
      ram_waddr = sw_waddr;
      ram_wdata = sw_wdata;
      ram_raddr = sw_raddr;
    end else begin
      ram_we    = (state == ST_DECODE) && !act_q && !is_ctrl;
      ram_waddr = cell_addr;
      ram_wdata = code_q;
      ram_raddr = cell_addr;
    end
  end

  tcw_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // captured input transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act_q  <= s_tuser[0];
      code_q <= s_tdata[7:0];
      rrow_q <= s_tdata[12:8];
      rcol_q <= s_tdata[19:13];
    end
  end

  // sequencer, cursor and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_pass <= 1'b1;
      cur_row   <= '0;
      cur_col   <= '0;
      res_cell  <= '0;
      res_bell  <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
      m_tuser   <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          state <= ST_SWEEP;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          res_cell <= '0;
          res_bell <= !act_q && (code_q == CH_BEL);
          if (act_q) begin
            state <= rd_in_range ? ST_RDWAIT : ST_DONE;
          end else begin
            state <= (sw_cmd.go_clear || sw_cmd.go_scroll) ? ST_SWEEP : ST_DONE;
            if (code_q == CH_FF) begin
              cur_row <= '0;
              cur_col <= '0;
            end else if (code_q == CH_CR) begin
              cur_col <= '0;
            end else if (code_q == CH_LF) begin
              if (!row_last) begin
                cur_row <= cur_row + ROW_W'(1);
              end
            end else if (!is_ctrl) begin
              if (col_last) begin
                cur_col <= '0;
                if (!row_last) begin
                  cur_row <= cur_row + ROW_W'(1);
                end
              end else begin
                cur_col <= cur_col + COL_W'(1);
              end
            end
          end
        end
        ST_RDWAIT: begin
          res_cell <= ram_rdata;
          state    <= ST_DONE;
        end
        ST_SWEEP: begin
          if (sw_stat.done) begin
            init_pass <= 1'b0;
            state     <= init_pass ? ST_IDLE : ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, 7'(cur_col), 5'(cur_row), res_cell};
            m_tuser  <= res_bell;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_text_terminal_cell_writer.sv
// self-checking testbench for text_terminal_cell_writer: directed table, then random traffic
// keeps its own screen mirror and cursor to predict the results of random items and untyped directed rows
// depends on tcw_pkg and the text_terminal_cell_writer rtl
`timescale 1ns / 1ps

module tb_text_terminal_cell_writer
  import tcw_pkg::*;
();

  localparam int TERM_ROWS     = 25;
  localparam int TERM_COLS     = 80;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int SWEEP_BUDGET  = 300;    // scrolls plus clears, each a full sweep of the screen
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 20000;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic {ACT_PUT = 1'b0, ACT_READ = 1'b1} act_e;
  typedef enum {MIX_ALL, MIX_TEXT, MIX_NEWLINES, MIX_READS} mix_e;

  typedef struct packed {
    act_e       action;
    logic [7:0] code;
    logic [4:0] rrow;
    logic [6:0] rcol;
  } term_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [4:0] crow;
    logic [6:0] ccol;
    logic       bell;
  } term_view_t;

  typedef struct packed {
    term_item_t item;
    bit         typed;
    term_view_t view;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    // reads of a fresh screen, corners and outside the screen
    '{'{ACT_READ, CH_BEL, 5'd0,  7'd0},   1'b1, '{8'h20, 5'd0, 7'd0, 1'b0}},
    '{'{ACT_READ, 8'h00,  5'd24, 7'd79},  1'b1, '{8'h20, 5'd0, 7'd0, 1'b0}},
    '{'{ACT_READ, 8'hFF,  5'd31, 7'd127}, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
    '{'{ACT_READ, 8'h00,  5'd25, 7'd0},   1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
    '{'{ACT_READ, 8'h00,  5'd0,  7'd80},  1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
    // bell, then plain characters including the byte extremes
    '{'{ACT_PUT,  CH_BEL, 5'd0,  7'd0},   1'b1, '{8'h00, 5'd0, 7'd0, 1'b1}},
    '{'{ACT_PUT,  8'h41,  5'd31, 7'd127}, 1'b1, '{8'h00, 5'd0, 7'd1, 1'b0}},
    '{'{ACT_READ, 8'h00,  5'd0,  7'd0},   1'b1, '{8'h41, 5'd0, 7'd1, 1'b0}},
    '{'{ACT_PUT,  8'h00,  5'd0,  7'd0},   1'b1, '{8'h00, 5'd0, 7'd2, 1'b0}},
    '{'{ACT_PUT,  8'hFF,  5'd0,  7'd0},   1'b1, '{8'h00, 5'd0, 7'd3, 1'b0}},
    '{'{ACT_READ, 8'h00,  5'd0,  7'd1},   1'b1, '{8'h00, 5'd0, 7'd3, 1'b0}},
    '{'{ACT_READ, 8'h00,  5'd0,  7'd2},   1'b1, '{8'hFF, 5'd0, 7'd3, 1'b0}},
    // carriage return and line feed
    '{'{ACT_PUT,  CH_CR,  5'd0,  7'd0},   1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
    '{'{ACT_PUT,  CH_LF,  5'd0,  7'd0},   1'b1, '{8'h00, 5'd1, 7'd0, 1'b0}},
    '{'{ACT_PUT,  8'h7A,  5'd0,  7'd0},   1'b1, '{8'h00, 5'd1, 7'd1, 1'b0}},
    // form feed clears and homes
    '{'{ACT_PUT,  CH_FF,  5'd0,  7'd0},   1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
    '{'{ACT_READ, 8'h00,  5'd0,  7'd0},   1'b1, '{8'h20, 5'd0, 7'd0, 1'b0}},
    '{'{ACT_READ, 8'h00,  5'd1,  7'd0},   1'b1, '{8'h20, 5'd0, 7'd0, 1'b0}},
    // a few rows left to the screen mirror
    '{'{ACT_PUT,  8'h80,  5'd0,  7'd0},   1'b0, '0},
    '{'{ACT_PUT,  8'h7F,  5'd0,  7'd0},   1'b0, '0},
    '{'{ACT_READ, 8'h00,  5'd0,  7'd1},   1'b0, '0},
    '{'{ACT_PUT,  CH_CR,  5'd0,  7'd0},   1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
  logic [0:0]  s_tuser = '0;    // action[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // cell_char[7:0], cursor_row[12:8], cursor_col[19:13], zero pad
  logic [0:0]  m_tuser;         // bell[0]

  // screen mirror and cursor
  logic [7:0]  screen_mirror [TERM_ROWS][TERM_COLS];
  int unsigned cur_row, cur_col, sweep_count;

  term_view_t  expected_views [$];
  int unsigned err_count = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned stall_cycles = 0;

  text_terminal_cell_writer #(.ROWS(TERM_ROWS), .COLS(TERM_COLS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void blank_screen();
    foreach (screen_mirror[r, c]) screen_mirror[r][c] = CH_SPACE;
  endfunction

  // next row, scrolling the screen up at the bottom
  function automatic void advance_row();
    cur_row++;
    if (cur_row >= TERM_ROWS) begin
      for (int r = 0; r < TERM_ROWS - 1; r++) screen_mirror[r] = screen_mirror[r + 1];
      for (int c = 0; c < TERM_COLS; c++) screen_mirror[TERM_ROWS - 1][c] = CH_SPACE;
      cur_row = TERM_ROWS - 1;
      sweep_count++;
    end
  endfunction

  // apply one transfer to the mirror and return the result it should produce
  function automatic term_view_t apply_item(term_item_t it);
    term_view_t v;
    v = '0;
    if (it.action == ACT_READ) begin
      if (it.rrow < TERM_ROWS && it.rcol < TERM_COLS)
        v.cell_char = screen_mirror[it.rrow][it.rcol];
    end else begin
      case (it.code)
        CH_FF: begin
          blank_screen();
          cur_row = 0;
          cur_col = 0;
          sweep_count++;
        end
        CH_CR:  cur_col = 0;
        CH_LF:  advance_row();
        CH_BEL: v.bell = 1'b1;
        default: begin
          screen_mirror[cur_row][cur_col] = it.code;
          cur_col++;
          if (cur_col >= TERM_COLS) begin
            cur_col = 0;
            advance_row();
          end
        end
      endcase
    end
    v.crow = 5'(cur_row);
    v.ccol = 7'(cur_col);
    return v;
  endfunction

  // random item; past the sweep budget only reads, returns and bells
  function automatic term_item_t pick_item(mix_e mix);
    term_item_t  it;
    int unsigned roll, read_pct;
    it.rrow = 5'($urandom_range(0, 31));
    it.rcol = 7'($urandom_range(0, 127));
    it.code = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (sweep_count >= SWEEP_BUDGET) begin
      it.action = (roll < 70) ? ACT_READ : ACT_PUT;
      it.code = (roll % 2 == 0) ? CH_CR : CH_BEL;
      return it;
    end
    case (mix)
      MIX_TEXT:     read_pct = 10;
      MIX_NEWLINES: read_pct = 20;
      MIX_READS:    read_pct = 85;
      default:      read_pct = 40;
    endcase
    it.action = (roll < read_pct) ? ACT_READ : ACT_PUT;
    roll = $urandom_range(0, 99);
    if (it.action == ACT_READ) begin
      // mostly inside the screen
      if (roll < 85) begin
        it.rrow = 5'($urandom_range(0, TERM_ROWS - 1));
        it.rcol = 7'($urandom_range(0, TERM_COLS - 1));
      end
    end else begin
      case (mix)
        MIX_TEXT: begin
          if (roll < 2)       it.code = CH_LF;
          else if (roll < 4)  it.code = CH_CR;
          else if (roll < 90) it.code = 8'($urandom_range(8'h20, 8'h7E));
        end
        MIX_NEWLINES: begin
          if (roll < 30)      it.code = CH_LF;
          else if (roll < 35) it.code = CH_CR;
        end
        MIX_ALL: begin
          if (roll < 5)       it.code = CH_LF;
          else if (roll < 9)  it.code = CH_CR;
          else if (roll < 12) it.code = CH_BEL;
          else if (roll < 13) it.code = CH_FF;
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // random sender gaps
  task automatic sender_gaps();
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // offer one transfer and hold it until accepted
  task automatic send_item(term_item_t it, bit typed, term_view_t typed_view);
    term_view_t pred;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it.rcol, it.rrow, it.code};
    s_tuser  <= it.action;
    do @(posedge clk); while (!s_tready);
    pred = apply_item(it);
    expected_views.push_back(typed ? typed_view : pred);
  endtask

  task automatic report_error(string what, term_view_t want, term_view_t got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display({"%0t %s: expected cell=%02h row=%0d col=%0d bell=%0d, ",
                "got cell=%02h row=%0d col=%0d bell=%0d"},
               $realtime, what, want.cell_char, want.crow, want.ccol, want.bell,
               got.cell_char, got.crow, got.ccol, got.bell);
  endtask

  // receiver: random stalls, a stretch with none, and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_req = 1'b0;
      end else begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    term_view_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[12:8], m_tdata[19:13], m_tuser[0]};
      if (expected_views.size() == 0) begin
        report_error("result with nothing expected", '0, got);
      end else begin
        want = expected_views.pop_front();
        if (got.cell_char !== want.cell_char || got.crow !== want.crow ||
            got.ccol !== want.ccol || got.bell !== want.bell)
          report_error("result mismatch", want, got);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // main sequence
  initial begin
    int unsigned sent, seg, seg_len;
    mix_e        mix;
    blank_screen();
    cur_row = 0;
    cur_col = 0;
    sweep_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      sender_gaps();
      send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].view);
    end

    // random segments: newlines first to reach the bottom, then long text to wrap
    sent = 0;
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seg == 0)      mix = MIX_NEWLINES;
      else if (seg == 1) mix = MIX_TEXT;
      else               mix = mix_e'($urandom_range(0, 3));
      no_idle = (seg == 5);
      if (seg == 3) hold_req = 1'b1;
      seg_len = $urandom_range(60, 140);
      for (int i = 0; i < seg_len; i++) begin
        sender_gaps();
        send_item(pick_item(mix), 1'b0, '0);
      end
      sent += seg_len;
      // sender pause until the block has drained
      if (seg % 4 == 2) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_views.size() == 0);
      end
      seg++;
    end
    no_idle = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_views.size() == 0);
    repeat (50) @(posedge clk);
    if (expected_views.size() != 0)
      report_error("results never arrived", expected_views[0], '0);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
